// ===== src/oneshot_periodic_timer_bank_assert.svh =====
// assertion macros shared by the timer bank modules
`ifndef ONESHOT_PERIODIC_TIMER_BANK_ASSERT_SVH
`define ONESHOT_PERIODIC_TIMER_BANK_ASSERT_SVH

// condition implies consequence in the same cycle
`define OPTB_ASSERT_SAME(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("timer bank assertion failed");

// condition implies consequence in the next cycle
`define OPTB_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("timer bank assertion failed");

`endif

// ===== src/optb_pkg.sv =====
// shared types and constants of the timer bank
`default_nettype none

package optb_pkg;

    localparam int NUM_SLOTS_DEF = 10;
    localparam logic [15:0] TICK_STEP_RESET = 16'd10;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ALLOC,
        ST_STOP,
        ST_TICK,
        ST_FLUSH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic scan_clr;
        logic start_step;
        logic alloc;
        logic stop_step;
        logic tick_walk;
        logic flush;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] in_mode;
        logic       scan_last;
        logic       hit;
        logic       pend_valid;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/optb_if.sv =====
// channel interfaces of the timer bank
`default_nettype none

interface optb_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [31:0] interval_ms;
    logic        repeat_req;

    modport source (output valid, output mode, output timer_id, output interval_ms,
                    output repeat_req, input ready);
    modport sink (input valid, input mode, input timer_id, input interval_ms,
                  input repeat_req, output ready);
endinterface

interface optb_exp_if;
    logic       valid;
    logic       ready;
    logic [7:0] expired_id;
    logic       last_expiry;

    modport source (output valid, output expired_id, output last_expiry, input ready);
    modport sink (input valid, input expired_id, input last_expiry, output ready);
endinterface

interface optb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/optb_ctrl.sv =====
// sequencing state machine of the timer bank
`default_nettype none
`include "oneshot_periodic_timer_bank_assert.svh"

module optb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  optb_pkg::sts_t sts,
    output optb_pkg::ctl_t ctl
);

    optb_pkg::state_t state_reg;
    optb_pkg::state_t state_next;
    logic             walk_ok;

    // a tick walk waits when a second expiry finds the output still full
    assign walk_ok = !(sts.hit && sts.pend_valid && !sts.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= optb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            optb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.in_mode)
                        optb_pkg::MODE_TICK:  state_next = optb_pkg::ST_TICK;
                        optb_pkg::MODE_START: state_next = optb_pkg::ST_START;
                        optb_pkg::MODE_STOP:  state_next = optb_pkg::ST_STOP;
                        optb_pkg::MODE_NONE:  state_next = optb_pkg::ST_IDLE;
                    endcase
                end
            end
            optb_pkg::ST_START:
            begin
                priority if (sts.hit)
                    state_next = optb_pkg::ST_IDLE;
                else if (sts.scan_last)
                    state_next = optb_pkg::ST_ALLOC;
            end
            optb_pkg::ST_ALLOC:
            begin
                state_next = optb_pkg::ST_IDLE;
            end
            optb_pkg::ST_STOP:
            begin
                if (sts.scan_last)
                    state_next = optb_pkg::ST_IDLE;
            end
            optb_pkg::ST_TICK:
            begin
                if (walk_ok && sts.scan_last)
                    state_next = optb_pkg::ST_FLUSH;
            end
            optb_pkg::ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                    state_next = optb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        ctl            = '0;
        unique case (state_reg)
            optb_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctl.latch    = in_valid;
                ctl.scan_clr = in_valid;
            end
            optb_pkg::ST_START:
            begin
                ctl.start_step = 1'b1;
            end
            optb_pkg::ST_ALLOC:
            begin
                ctl.alloc = 1'b1;
            end
            optb_pkg::ST_STOP:
            begin
                ctl.stop_step = 1'b1;
            end
            optb_pkg::ST_TICK:
            begin
                ctl.tick_walk = walk_ok;
            end
            optb_pkg::ST_FLUSH:
            begin
                ctl.flush = sts.pend_valid && sts.out_free;
            end
        endcase
    end

    `OPTB_ASSERT_SAME(a_idle_no_pending, clk, rst_n,
        state_reg == optb_pkg::ST_IDLE, !sts.pend_valid)
    `OPTB_ASSERT_SAME(a_flush_has_room, clk, rst_n,
        ctl.flush, sts.pend_valid && sts.out_free)

endmodule

`default_nettype wire

// ===== src/optb_datapath.sv =====
// slot storage, scan index, tick arithmetic and result register
`default_nettype none
`include "oneshot_periodic_timer_bank_assert.svh"

module optb_datapath #(
    parameter int NUM_SLOTS = optb_pkg::NUM_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  optb_pkg::ctl_t ctl,
    output optb_pkg::sts_t sts,
    input  logic [1:0]     in_mode,
    input  logic [7:0]     in_timer_id,
    input  logic [31:0]    in_interval_ms,
    input  logic           in_repeat_req,
    input  logic           cfg_valid,
    input  logic [15:0]    cfg_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_expired_id,
    output logic           out_last_expiry
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [15:0]          tick_step_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic                 slot_periodic_reg  [NUM_SLOTS];
    logic [31:0]          slot_interval_reg  [NUM_SLOTS];
    logic [31:0]          slot_remaining_reg [NUM_SLOTS];
    logic [7:0]           slot_owner_reg     [NUM_SLOTS];

    logic [1:0]           mode_reg;
    logic [7:0]           id_reg;
    logic [31:0]          ms_reg;
    logic                 rep_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 free_found_reg;
    logic                 pend_valid_reg;
    logic [7:0]           pend_id_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_id_reg;
    logic                 out_last_reg;

    logic                 active_cur;
    logic [7:0]           owner_cur;
    logic [31:0]          rem_cur;
    logic                 rem_le;
    logic                 hit;
    logic                 scan_last;
    logic                 out_free;
    logic                 push;
    logic                 advance;

    assign active_cur = active_reg[idx_reg];
    assign owner_cur  = slot_owner_reg[idx_reg];
    assign rem_cur    = slot_remaining_reg[idx_reg];
    // a slot expires when its count does not exceed the step
    assign rem_le     = rem_cur <= {16'd0, tick_step_reg};
    assign hit        = active_cur && ((mode_reg == optb_pkg::MODE_TICK) ? rem_le
                                                                          : (owner_cur == id_reg));
    assign scan_last  = idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign out_free   = !out_valid_reg || out_ready;
    assign push       = (ctl.tick_walk && hit && pend_valid_reg) || ctl.flush;
    assign advance    = (ctl.start_step || ctl.stop_step || ctl.tick_walk) && !scan_last;

    assign sts.in_mode    = in_mode;
    assign sts.scan_last  = scan_last;
    assign sts.hit        = hit;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    assign out_valid       = out_valid_reg;
    assign out_expired_id  = out_id_reg;
    assign out_last_expiry = out_last_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg  <= optb_pkg::TICK_STEP_RESET;
            active_reg     <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                tick_step_reg <= cfg_data;

            if (ctl.scan_clr)
                idx_reg <= '0;
            else if (advance)
                idx_reg <= idx_reg + IDX_W'(1);

            if (ctl.scan_clr)
                free_found_reg <= 1'b0;
            else if (ctl.start_step && !active_cur)
                free_found_reg <= 1'b1;

            if (ctl.alloc && free_found_reg)
                active_reg[free_idx_reg] <= 1'b1;
            else if (ctl.stop_step && hit)
                active_reg[idx_reg] <= 1'b0;
            else if (ctl.tick_walk && hit && !slot_periodic_reg[idx_reg])
                active_reg[idx_reg] <= 1'b0;

            if (ctl.tick_walk && hit)
                pend_valid_reg <= 1'b1;
            else if (ctl.flush)
                pend_valid_reg <= 1'b0;

            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            mode_reg <= in_mode;
            id_reg   <= in_timer_id;
            ms_reg   <= in_interval_ms;
            rep_reg  <= in_repeat_req;
        end

        if (ctl.start_step && !active_cur && !free_found_reg)
            free_idx_reg <= idx_reg;

        if (ctl.start_step && hit)
        begin
            slot_interval_reg[idx_reg]  <= ms_reg;
            slot_remaining_reg[idx_reg] <= ms_reg;
            slot_periodic_reg[idx_reg]  <= rep_reg;
        end
        else if (ctl.alloc && free_found_reg)
        begin
            slot_interval_reg[free_idx_reg]  <= ms_reg;
            slot_remaining_reg[free_idx_reg] <= ms_reg;
            slot_periodic_reg[free_idx_reg]  <= rep_reg;
            slot_owner_reg[free_idx_reg]     <= id_reg;
        end
        else if (ctl.tick_walk && active_cur)
        begin
            if (hit)
                slot_remaining_reg[idx_reg] <= slot_interval_reg[idx_reg];
            else
                slot_remaining_reg[idx_reg] <= rem_cur - {16'd0, tick_step_reg};
        end

        if (ctl.tick_walk && hit)
            pend_id_reg <= owner_cur;

        if (push)
        begin
            out_id_reg   <= pend_id_reg;
            out_last_reg <= ctl.flush;
        end
    end

    `OPTB_ASSERT_SAME(a_push_has_room, clk, rst_n,
        ctl.tick_walk && hit && pend_valid_reg, out_free)
    `OPTB_ASSERT_NEXT(a_scan_restart, clk, rst_n,
        ctl.latch, (idx_reg == '0) && !free_found_reg)

endmodule

`default_nettype wire

// ===== src/oneshot_periodic_timer_bank.sv =====
// top level of the one-shot and periodic timer bank
`default_nettype none

// bank of NUM_SLOTS software timers driven by tick, start and stop requests on
// cmd. a request is taken only while the controller is idle and is then worked
// by a walk over the slots, one slot per clock while the walk is not paused,
// through a single 32-bit compare/subtract unit. a tick accepts, walks and
// flushes the last expiry; a start stops at an active slot with the same id,
// else allocates the lowest free slot in the state after the walk; a stop
// walks all slots and an unused mode is accepted with no walk. a tick walk
// pauses while a second expiry finds the previous one still waiting in the
// output register. expiries leave on expiry in slot order, with last_expiry
// set on the final one of each tick; start and stop give none. tick_step is
// written through cfg, always ready; the user must write it only while the
// bank is idle, the block itself does not enforce this.

module oneshot_periodic_timer_bank #(
    parameter int NUM_SLOTS = optb_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    optb_cmd_if.sink   cmd,
    optb_exp_if.source expiry,
    optb_cfg_if.sink   cfg
);

    optb_pkg::ctl_t ctl;
    optb_pkg::sts_t sts;
    logic           in_ready;

    // configuration is taken every cycle
    assign cfg.ready = 1'b1;
    assign cmd.ready = in_ready;

    // sequencer: idle, start walk, allocate, stop walk, tick walk, flush
    optb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // slot storage, arithmetic and the result register
    optb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .in_mode         (cmd.mode),
        .in_timer_id     (cmd.timer_id),
        .in_interval_ms  (cmd.interval_ms),
        .in_repeat_req   (cmd.repeat_req),
        .cfg_valid       (cfg.valid),
        .cfg_data        (cfg.data),
        .out_valid       (expiry.valid),
        .out_ready       (expiry.ready),
        .out_expired_id  (expiry.expired_id),
        .out_last_expiry (expiry.last_expiry)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the one-shot and periodic timer bank

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANK_SLOTS = optb_pkg::NUM_SLOTS_DEF;
    localparam int PHASE_REQUESTS = 64;
    localparam int PHASE_COUNT = 5;
    // a start or stop walk may still run after the last expiry has left
    localparam int SETTLE_CYCLES = 2 * BANK_SLOTS + 6;
    localparam int CYCLE_LIMIT = 200000;

    // one request on the command channel
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  timer_id;
        logic [31:0] interval_ms;
        logic        repeat_req;
    } cmd_req_t;

    // one expiry as it should leave the bank
    typedef struct packed {
        logic [7:0] expired_id;
        logic       last_expiry;
    } expiry_t;

    // directed row: request fields, then an optional hand-typed outcome
    // (typed set: typed_one says whether a single expiry of typed_id is due)
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  timer_id;
        logic [31:0] interval_ms;
        logic        repeat_req;
        logic        typed;
        logic        typed_one;
        logic [7:0]  typed_id;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    // tick step stays at its reset value of 10 for the whole table
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty bank, unused mode, stop of an unknown id: nothing comes out
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b0, 8'd0},
        '{optb_pkg::MODE_NONE,  8'hA5,  32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, 8'd0},
        '{optb_pkg::MODE_STOP,  8'd5,   32'd0,          1'b0, 1'b1, 1'b0, 8'd0},
        // zero interval one-shot expires on the next tick
        '{optb_pkg::MODE_START, 8'd0,   32'd0,          1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b1, 8'd0},
        // zero interval periodic expires on every tick
        '{optb_pkg::MODE_START, 8'd255, 32'd0,          1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b1, 8'd255},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b1, 8'd255},
        // restart of a running id turns it into a one-shot of 25
        '{optb_pkg::MODE_START, 8'd255, 32'd25,         1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd7,   32'd10,         1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b1, 8'd7},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b1, 1'b1, 8'd7},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_STOP,  8'd7,   32'd0,          1'b0, 1'b0, 1'b0, 8'd0},
        // fill every slot, widest interval first
        '{optb_pkg::MODE_START, 8'd1,   32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd2,   32'd10,         1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd3,   32'd20,         1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd4,   32'd30,         1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd5,   32'd40,         1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd6,   32'd50,         1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd7,   32'd60,         1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd8,   32'd70,         1'b0, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd9,   32'd80,         1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd10,  32'd90,         1'b0, 1'b0, 1'b0, 8'd0},
        // bank full: new id is dropped, a known id still restarts
        '{optb_pkg::MODE_START, 8'd11,  32'd5,          1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_START, 8'd3,   32'd0,          1'b1, 1'b0, 1'b0, 8'd0},
        '{optb_pkg::MODE_TICK,  8'd0,   32'd0,          1'b0, 1'b0, 1'b0, 8'd0}
    };

    logic clk;
    logic rst_n;

    optb_cmd_if cmd_ch();
    optb_exp_if exp_ch();
    optb_cfg_if cfg_ch();

    oneshot_periodic_timer_bank #(
        .NUM_SLOTS(BANK_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .expiry(exp_ch),
        .cfg(cfg_ch)
    );

    // predicted bank contents
    logic        slot_on     [BANK_SLOTS];
    logic        slot_repeat [BANK_SLOTS];
    logic [31:0] slot_period [BANK_SLOTS];
    logic [31:0] slot_left   [BANK_SLOTS];
    logic [7:0]  slot_id     [BANK_SLOTS];
    logic [15:0] step_ms;

    expiry_t fresh_expiries[$];    // expiries of the request just taken
    expiry_t pending_expiries[$];  // expiries still owed by the bank

    int  mismatches;
    bit  idle_on;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // bank predictor: applies one request, leaves its expiries in fresh_expiries
    function automatic void advance_bank(input cmd_req_t r);
        int hit;
        fresh_expiries.delete();
        hit = -1;
        case (r.mode)
            optb_pkg::MODE_START:
            begin
                // a running slot with the same id wins over the lowest free one
                for (int s = 0; s < BANK_SLOTS; s++)
                    if (hit < 0 && slot_on[s] && slot_id[s] == r.timer_id)
                        hit = s;
                for (int s = 0; s < BANK_SLOTS; s++)
                    if (hit < 0 && !slot_on[s])
                        hit = s;
                // no hit means bank full, request dropped
                if (hit >= 0)
                begin
                    slot_on[hit]     = 1'b1;
                    slot_id[hit]     = r.timer_id;
                    slot_repeat[hit] = r.repeat_req;
                    slot_period[hit] = r.interval_ms;
                    slot_left[hit]   = r.interval_ms;
                end
            end
            optb_pkg::MODE_STOP:
            begin
                for (int s = 0; s < BANK_SLOTS; s++)
                    if (slot_on[s] && slot_id[s] == r.timer_id)
                        slot_on[s] = 1'b0;
            end
            optb_pkg::MODE_TICK:
            begin
                for (int s = 0; s < BANK_SLOTS; s++)
                begin
                    if (slot_on[s])
                    begin
                        // saturating countdown
                        slot_left[s] = (slot_left[s] >= 32'(step_ms)) ?
                                       slot_left[s] - 32'(step_ms) : 32'd0;
                        if (slot_left[s] == 32'd0)
                        begin
                            fresh_expiries.push_back('{slot_id[s], 1'b0});
                            if (slot_repeat[s])
                                slot_left[s] = slot_period[s];
                            else
                                slot_on[s] = 1'b0;
                        end
                    end
                end
                if (fresh_expiries.size() > 0)
                    fresh_expiries[fresh_expiries.size() - 1].last_expiry = 1'b1;
            end
            default:
            begin
                // unused mode is ignored
            end
        endcase
    endfunction

    // random request: small id pool so restarts, stops and a full bank happen,
    // intervals near multiples of the step so that timers actually run out
    function automatic cmd_req_t make_request();
        cmd_req_t r;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 7)
            r.mode = optb_pkg::MODE_TICK;
        else if (pick < 16)
            r.mode = optb_pkg::MODE_START;
        else if (pick < 19)
            r.mode = optb_pkg::MODE_STOP;
        else
            r.mode = optb_pkg::MODE_NONE;
        if ($urandom_range(0, 7) == 0)
            r.timer_id = 8'($urandom);
        else
            r.timer_id = 8'($urandom_range(0, 11));
        if ($urandom_range(0, 7) == 0)
            r.interval_ms = $urandom;
        else
            r.interval_ms = 32'(step_ms) * $urandom_range(0, 3) +
                            $urandom_range(0, 32'(step_ms));
        r.repeat_req = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // one request on cmd; valid stays high when the next one follows back to back
    task automatic send_request(input cmd_req_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= r.mode;
        cmd_ch.timer_id    <= r.timer_id;
        cmd_ch.interval_ms <= r.interval_ms;
        cmd_ch.repeat_req  <= r.repeat_req;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
    endtask

    // let the bank run dry before touching tick_step or ending
    task automatic drain_bank();
        cmd_ch.valid <= 1'b0;
        while (pending_expiries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_step(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        step_ms = value;
    endtask

    // expiry side: random stalls, each taken expiry checked against the oldest owed
    initial
    begin
        int stall;
        expiry_t want;
        exp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                exp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            exp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (exp_ch.valid !== 1'b1);
            if (pending_expiries.size() == 0)
            begin
                $error("expired_id expected none, got %0d", exp_ch.expired_id);
                mismatches++;
            end
            else
            begin
                want = pending_expiries.pop_front();
                if (exp_ch.expired_id !== want.expired_id)
                begin
                    $error("expired_id expected %0d, got %0d",
                           want.expired_id, exp_ch.expired_id);
                    mismatches++;
                end
                if (exp_ch.last_expiry !== want.last_expiry)
                begin
                    $error("last_expiry expected %0b, got %0b",
                           want.last_expiry, exp_ch.last_expiry);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        cmd_req_t req;
        logic [15:0] phase_step;
        mismatches = 0;
        idle_on = 1'b1;
        step_ms = optb_pkg::TICK_STEP_RESET;
        for (int s = 0; s < BANK_SLOTS; s++)
        begin
            slot_on[s]     = 1'b0;
            slot_repeat[s] = 1'b0;
            slot_period[s] = 32'd0;
            slot_left[s]   = 32'd0;
            slot_id[s]     = 8'd0;
        end
        // every input known from time zero
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.mode        <= optb_pkg::MODE_TICK;
        cmd_ch.timer_id    <= 8'd0;
        cmd_ch.interval_ms <= 32'd0;
        cmd_ch.repeat_req  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= 16'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset tick step
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            req = '{DIRECTED[i].mode, DIRECTED[i].timer_id,
                    DIRECTED[i].interval_ms, DIRECTED[i].repeat_req};
            send_request(req);
            advance_bank(req);
            if (DIRECTED[i].typed)
            begin
                if (DIRECTED[i].typed_one)
                    pending_expiries.push_back('{DIRECTED[i].typed_id, 1'b1});
            end
            else
            begin
                foreach (fresh_expiries[j])
                    pending_expiries.push_back(fresh_expiries[j]);
            end
        end

        // random phases: smallest step, largest step, zero step, any step, reset step
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: phase_step = 16'd1;
                1: phase_step = 16'hFFFF;
                2: phase_step = 16'd0;
                3: phase_step = 16'($urandom_range(2, 65534));
                default: phase_step = optb_pkg::TICK_STEP_RESET;
            endcase
            drain_bank();
            write_tick_step(phase_step);
            // some phases run with no idling on either side
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                req = make_request();
                send_request(req);
                advance_bank(req);
                foreach (fresh_expiries[j])
                    pending_expiries.push_back(fresh_expiries[j]);
            end
        end

        drain_bank();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== oneshot_periodic_timer_bank.f =====
+incdir+src
src/optb_pkg.sv
src/optb_if.sv
src/optb_ctrl.sv
src/optb_datapath.sv
src/oneshot_periodic_timer_bank.sv
verif/testbench.sv
